// ----- design/fpsqrt_pkg.sv -----
// Shared types and constants for the fixed-point square root pipeline.
// Used by fpsqrt_step and fixed_point_square_root; depends on nothing.
package fpsqrt_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned ROOT_W  = 25;
    localparam int unsigned WORD_W  = 32;

    // Step counts and top bit positions of the two recurrence passes.
    localparam int unsigned PASS1_STEPS   = 16;
    localparam int unsigned PASS1_TOP_BIT = 30;
    localparam int unsigned PASS2_STEPS   = 8;
    localparam int unsigned PASS2_TOP_BIT = 14;

    localparam logic [WORD_W-1:0] REM_LIMIT = 32'd65535;
    localparam logic [WORD_W-1:0] HALF_LSB  = 32'h0000_8000;

    typedef struct packed {
        logic              neg;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] root;
    } fpsqrt_word_t;

endpackage

// ----- design/fpsqrt_step.sv -----
// One registered step of the binary digit-by-digit square root recurrence.
// Depends on fpsqrt_pkg for the pipeline word type.
module fpsqrt_step #(
    parameter int unsigned BIT_POS = 0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  fpsqrt_pkg::fpsqrt_word_t in_data,
    output logic                     out_valid,
    output fpsqrt_pkg::fpsqrt_word_t out_data
);
    import fpsqrt_pkg::*;

    localparam logic [WORD_W-1:0] BIT_VAL = WORD_W'(1) << BIT_POS;

    logic              out_valid_reg;
    fpsqrt_word_t      out_data_reg;
    fpsqrt_word_t      out_data_next;
    logic [WORD_W-1:0] trial;

    always_comb
    begin
        trial              = in_data.root + BIT_VAL;
        out_data_next.neg  = in_data.neg;
        if (in_data.num >= trial)
        begin
            out_data_next.num  = in_data.num - trial;
            out_data_next.root = (in_data.root >> 1) + BIT_VAL;
        end
        else
        begin
            out_data_next.num  = in_data.num;
            out_data_next.root = in_data.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- design/fixed_point_square_root.sv -----
// Top level of the Q15.16 fixed-point square root pipeline.
// Depends on fpsqrt_pkg and fpsqrt_step.
//
// Usage:
// The input channel (in_valid, in_stall, value) takes one signed Q15.16 word.
// The output channel (out_valid, out_stall, root) returns the Q8.16 square
// root of its magnitude, negated when the operand was negative.
// A word is moved on a rising edge where valid is high and stall is low.
// The result reaches the output register through one stage for the magnitude,
// sixteen first-pass steps, one rescaling stage, eight second-pass steps, one
// rounding stage and one sign stage. Throughput is one word per cycle while
// out_stall does not hold the pipeline, set by the one-step-per-stage
// pipeline.
// While a result sits on the output and out_stall is high, the whole
// pipeline holds and in_stall is raised; nothing is dropped or repeated.
// Reset clears all valid bits, so the pipeline comes up empty with
// out_valid low. No state is kept between words.
module fixed_point_square_root (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [fpsqrt_pkg::VALUE_W-1:0]  value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [fpsqrt_pkg::ROOT_W-1:0]   root
);
    import fpsqrt_pkg::*;

    logic                en;
    logic [VALUE_W-1:0]  raw;
    fpsqrt_word_t        mag_next;
    logic                mag_valid_reg;
    fpsqrt_word_t        mag_data_reg;

    logic                p1_valid [0:PASS1_STEPS];
    fpsqrt_word_t        p1_data  [0:PASS1_STEPS];

    logic [WORD_W-1:0]   diff;
    fpsqrt_word_t        scale_next;
    logic                scale_valid_reg;
    fpsqrt_word_t        scale_data_reg;

    logic                p2_valid [0:PASS2_STEPS];
    fpsqrt_word_t        p2_data  [0:PASS2_STEPS];

    logic                round_valid_reg;
    logic                round_neg_reg;
    logic [WORD_W-1:0]   round_root_reg;
    logic [WORD_W-1:0]   round_root_next;
    logic [WORD_W-1:0]   signed_root;

    logic                out_valid_reg;
    logic [ROOT_W-1:0]   root_reg;

    // The pipeline advances as a whole unless a finished word is held.
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // Magnitude stage.
    assign raw = value;
    always_comb
    begin
        mag_next.neg  = raw[VALUE_W-1];
        mag_next.num  = raw[VALUE_W-1] ? (WORD_W'(0) - raw) : raw;
        mag_next.root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mag_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_data_reg <= mag_next;
        end
    end

    assign p1_valid[0] = mag_valid_reg;
    assign p1_data[0]  = mag_data_reg;

    // First pass always starts at the top bit; steps whose bit exceeds the
    // operand leave a zero root untouched, so small operands come out the same.
    for (genvar k = 0; k < PASS1_STEPS; k++)
    begin : g_pass1
        fpsqrt_step #(
            .BIT_POS(PASS1_TOP_BIT - 2 * k)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (p1_valid[k]),
            .in_data  (p1_data[k]),
            .out_valid(p1_valid[k+1]),
            .out_data (p1_data[k+1])
        );
    end

    // Rescale remainder and root by 2^16; a remainder that would overflow
    // takes a half-LSB correction instead.
    always_comb
    begin
        diff           = p1_data[PASS1_STEPS].num - p1_data[PASS1_STEPS].root;
        scale_next.neg = p1_data[PASS1_STEPS].neg;
        if (p1_data[PASS1_STEPS].num > REM_LIMIT)
        begin
            scale_next.num  = {diff[15:0], 16'd0} - HALF_LSB;
            scale_next.root = {p1_data[PASS1_STEPS].root[15:0], 16'd0} + HALF_LSB;
        end
        else
        begin
            scale_next.num  = {p1_data[PASS1_STEPS].num[15:0], 16'd0};
            scale_next.root = {p1_data[PASS1_STEPS].root[15:0], 16'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            scale_valid_reg <= p1_valid[PASS1_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            scale_data_reg <= scale_next;
        end
    end

    assign p2_valid[0] = scale_valid_reg;
    assign p2_data[0]  = scale_data_reg;

    for (genvar k = 0; k < PASS2_STEPS; k++)
    begin : g_pass2
        fpsqrt_step #(
            .BIT_POS(PASS2_TOP_BIT - 2 * k)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (p2_valid[k]),
            .in_data  (p2_data[k]),
            .out_valid(p2_valid[k+1]),
            .out_data (p2_data[k+1])
        );
    end

    // Round up when the next root bit would be one.
    assign round_root_next = p2_data[PASS2_STEPS].root
                           + WORD_W'(p2_data[PASS2_STEPS].num > p2_data[PASS2_STEPS].root);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (en)
        begin
            round_valid_reg <= p2_valid[PASS2_STEPS];
            out_valid_reg   <= round_valid_reg;
        end
    end

    assign signed_root = round_neg_reg ? (WORD_W'(0) - round_root_reg) : round_root_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            round_neg_reg  <= p2_data[PASS2_STEPS].neg;
            round_root_reg <= round_root_next;
            root_reg       <= signed_root[ROOT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign root      = root_reg;

endmodule
